/* sv/rcpi_pkg.sv */
// Shared types and constants for the row center path interval block.
`timescale 1ns / 1ps
package rcpi_pkg;

   localparam int CFG_W           = 11;
   localparam int EDGE_W          = 10;
   localparam int COLOR_W         = 8;
   localparam int ROW_WIDTH_RESET = 640;
   localparam int ROW_WIDTH_MIN   = 2;

   localparam logic [COLOR_W-1:0] COLOR_FULL = 8'd255;
   localparam logic [COLOR_W-1:0] COLOR_HALF = 8'd128;
   localparam logic [COLOR_W-1:0] COLOR_NONE = 8'd0;

   // Classified pixel as it leaves the input register.
   typedef struct packed {
      logic bad;
      logic first_of_frame;
      logic last_of_row;
   } pixel_type;

endpackage

/* sv/row_center_path_interval.sv */
// Top level of the row center path interval block.
`timescale 1ns / 1ps
// Pixels enter on the req_ stream one per transaction, rows from the bottom
// of the image upward and pixels left to right. req_tuser marks the first
// pixel of a frame and req_tlast the last pixel of a row. For every row end
// one transaction leaves on the rsp_ stream: rsp_tuser says whether a path
// is open through the row center, and rsp_tdata carries the good column run
// around the center. Pixels that do not end a row give no transaction.
// The csr_ channel writes the row width; it is always ready and should be
// written only while no pixel is in flight.
// rsp_tvalid rises once a row's last pixel has passed the classifying input
// register and the run tracker has loaded the result register from it. One
// pixel is taken every cycle while no result is held back by the receiver;
// the tracker updates its state as it takes each pixel. When the receiver
// holds rsp_tready low, the result stays put, the tracker stops, and the
// input register holds at most one more pixel before req_tready drops.
// Reset clears the stream valids, the frame and row state, and sets the row
// width to 640 (clamped to MAX_WIDTH).
module row_center_path_interval #(
   parameter int MAX_WIDTH = 1024
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_tvalid,
   output logic                       req_tready,
   input  logic [23:0]                req_tdata,  // red, green, blue
   input  logic                       req_tuser,  // first_of_frame
   input  logic                       req_tlast,  // last_of_row
   output logic                       rsp_tvalid,
   input  logic                       rsp_tready,
   output logic [23:0]                rsp_tdata,  // left_edge, right_edge, zero pad
   output logic                       rsp_tuser,  // path_open
   input  logic                       csr_valid,
   output logic                       csr_ready,
   input  logic [rcpi_pkg::CFG_W-1:0] csr_data    // row_width
);
   import rcpi_pkg::*;

   pixel_type         pix;
   logic              pix_valid;
   logic              pix_ready;
   logic [EDGE_W-1:0] left_edge;
   logic [EDGE_W-1:0] right_edge;

   assign csr_ready = 1'b1;

   rcpi_in_stage u_in_stage (
      .clock          (clock),
      .reset          (reset),
      .in_valid       (req_tvalid),
      .in_ready       (req_tready),
      .red            (req_tdata[7:0]),
      .green          (req_tdata[15:8]),
      .blue           (req_tdata[23:16]),
      .first_of_frame (req_tuser),
      .last_of_row    (req_tlast),
      .pix_valid      (pix_valid),
      .pix_ready      (pix_ready),
      .pix            (pix)
   );

   rcpi_tracker #(
      .MAX_WIDTH (MAX_WIDTH)
   ) u_tracker (
      .clock      (clock),
      .reset      (reset),
      .csr_valid  (csr_valid),
      .csr_data   (csr_data),
      .pix_valid  (pix_valid),
      .pix_ready  (pix_ready),
      .pix        (pix),
      .rsp_valid  (rsp_tvalid),
      .rsp_ready  (rsp_tready),
      .path_open  (rsp_tuser),
      .left_edge  (left_edge),
      .right_edge (right_edge)
   );

   assign rsp_tdata = {4'b0000, right_edge, left_edge};

endmodule

/* sv/rcpi_in_stage.sv */
// Input register: classifies each pixel and holds it for the tracker.
`timescale 1ns / 1ps
module rcpi_in_stage (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        in_valid,
   output logic                        in_ready,
   input  logic [rcpi_pkg::COLOR_W-1:0] red,
   input  logic [rcpi_pkg::COLOR_W-1:0] green,
   input  logic [rcpi_pkg::COLOR_W-1:0] blue,
   input  logic                        first_of_frame,
   input  logic                        last_of_row,
   output logic                        pix_valid,
   input  logic                        pix_ready,
   output rcpi_pkg::pixel_type         pix
);
   import rcpi_pkg::*;

   logic      valid_ff;
   pixel_type pix_ff;
   pixel_type pix_in;
   logic      is_white;
   logic      is_orange;
   logic      is_black;

   assign is_white  = (red == COLOR_FULL) && (green == COLOR_FULL) && (blue == COLOR_FULL);
   assign is_orange = (red == COLOR_FULL) && (green == COLOR_HALF) && (blue == COLOR_NONE);
   assign is_black  = (red == COLOR_NONE) && (green == COLOR_NONE) && (blue == COLOR_NONE);

   always_comb begin
      pix_in.bad            = is_white || is_orange || is_black;
      pix_in.first_of_frame = first_of_frame;
      pix_in.last_of_row    = last_of_row;
   end

   // The register may refill in the same cycle that the tracker drains it.
   assign in_ready  = !valid_ff || pix_ready;
   assign pix_valid = valid_ff;
   assign pix       = pix_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
      if (in_ready && in_valid) begin
         pix_ff <= pix_in;
      end
   end

endmodule

/* sv/rcpi_tracker.sv */
// Per-row run tracking around the center column and the result register.
`timescale 1ns / 1ps
module rcpi_tracker #(
   parameter int MAX_WIDTH = 1024
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          csr_valid,
   input  logic [rcpi_pkg::CFG_W-1:0]    csr_data,
   input  logic                          pix_valid,
   output logic                          pix_ready,
   input  rcpi_pkg::pixel_type           pix,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic                          path_open,
   output logic [rcpi_pkg::EDGE_W-1:0]   left_edge,
   output logic [rcpi_pkg::EDGE_W-1:0]   right_edge
);
   import rcpi_pkg::*;

   localparam int XW = $clog2(MAX_WIDTH);
   localparam int WW = $clog2(MAX_WIDTH + 1);
   localparam int RST_WIDTH = (ROW_WIDTH_RESET > MAX_WIDTH) ? MAX_WIDTH : ROW_WIDTH_RESET;
   localparam logic [WW-1:0] NONE_MARK = WW'(MAX_WIDTH);
   localparam logic [XW-1:0] COL_LAST  = XW'(MAX_WIDTH - 1);

   logic [WW-1:0] width_ff;
   logic [WW-1:0] center_ff;
   logic [XW-1:0] column_ff;
   logic          closed_ff;
   logic [WW-1:0] left_bad_ff;
   logic [WW-1:0] right_bad_ff;
   logic          center_good_ff;
   logic          rsp_valid_ff;
   logic          path_open_ff;
   logic [EDGE_W-1:0] left_edge_ff;
   logic [EDGE_W-1:0] right_edge_ff;

   logic [WW-1:0] width_in;
   logic [XW-1:0] column_in;
   logic          closed_in;
   logic [WW-1:0] left_bad_in;
   logic [WW-1:0] right_bad_in;
   logic          center_good_in;
   logic [XW-1:0] x;
   logic [WW-1:0] x_ext;
   logic [WW-1:0] width_m1;
   logic [WW-1:0] right_clip;
   logic [WW-1:0] right_col;
   logic          fire;

   assign pix_ready = !rsp_valid_ff || rsp_ready;
   assign fire      = pix_valid && pix_ready;

   // Clamp the written width into the supported range once, at write time.
   always_comb begin
      if (csr_data < CFG_W'(ROW_WIDTH_MIN)) begin
         width_in = WW'(ROW_WIDTH_MIN);
      end else if (32'(csr_data) > 32'(MAX_WIDTH)) begin
         width_in = WW'(MAX_WIDTH);
      end else begin
         width_in = WW'(csr_data);
      end
   end

   assign width_m1 = width_ff - WW'(1);

   always_comb begin
      // A frame start discards whatever the previous row left behind.
      if (pix.first_of_frame) begin
         x              = '0;
         closed_in      = 1'b0;
         left_bad_in    = '0;
         right_bad_in   = NONE_MARK;
         center_good_in = 1'b0;
      end else begin
         x              = column_ff;
         closed_in      = closed_ff;
         left_bad_in    = left_bad_ff;
         right_bad_in   = right_bad_ff;
         center_good_in = center_good_ff;
      end
      x_ext = WW'(x);

      if (x_ext == center_ff) begin
         center_good_in = !pix.bad;
      end else if (x_ext < center_ff) begin
         if (pix.bad) begin
            left_bad_in = x_ext + WW'(1);
         end
      end else if (x_ext < width_m1) begin
         if (pix.bad && (right_bad_in == NONE_MARK)) begin
            right_bad_in = x_ext;
         end
      end

      column_in = (x == COL_LAST) ? x : x + XW'(1);

      if (pix.last_of_row && !center_good_in) begin
         closed_in = 1'b1;
      end

      // The last column of the row always counts as a bad column.
      right_clip = (right_bad_in > width_m1) ? width_m1 : right_bad_in;
      right_col  = (right_clip > center_ff) ? right_clip - WW'(1) : center_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff       <= WW'(RST_WIDTH);
         center_ff      <= WW'(RST_WIDTH / 2);
         column_ff      <= '0;
         closed_ff      <= 1'b0;
         left_bad_ff    <= '0;
         right_bad_ff   <= NONE_MARK;
         center_good_ff <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         if (csr_valid) begin
            width_ff  <= width_in;
            center_ff <= width_in >> 1;
         end
         if (fire) begin
            closed_ff <= closed_in;
            if (pix.last_of_row) begin
               column_ff      <= '0;
               left_bad_ff    <= '0;
               right_bad_ff   <= NONE_MARK;
               center_good_ff <= 1'b0;
            end else begin
               column_ff      <= column_in;
               left_bad_ff    <= left_bad_in;
               right_bad_ff   <= right_bad_in;
               center_good_ff <= center_good_in;
            end
         end
         if (pix_ready) begin
            rsp_valid_ff <= fire && pix.last_of_row;
         end
      end
      if (fire && pix.last_of_row) begin
         path_open_ff  <= !closed_in;
         left_edge_ff  <= closed_in ? '0 : EDGE_W'(left_bad_in);
         right_edge_ff <= closed_in ? '0 : EDGE_W'(right_col);
      end
   end

   assign rsp_valid  = rsp_valid_ff;
   assign path_open  = path_open_ff;
   assign left_edge  = left_edge_ff;
   assign right_edge = right_edge_ff;

endmodule

/* sv/rcpi_checker.sv */
// Port-level checks for the row center path interval block, bound to the top level.
`timescale 1ns / 1ps
module rcpi_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tready,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [23:0] rsp_tdata,
   input logic        rsp_tuser
);

   // A stalled result transaction holds its contents.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("result changed while stalled");

   // A closed row reports both edges as zero.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tuser |-> rsp_tdata == 24'd0)
      else $error("closed row with nonzero edges");

   // The input side only stalls when a result is held back by the receiver.
   assert property (@(posedge clock) disable iff (reset)
      !req_tready |-> rsp_tvalid && !rsp_tready)
      else $error("input stalled without output back-pressure");

   // Nothing is offered in the cycle after reset.
   assert property (@(posedge clock)
      $past(reset) && !reset |-> !rsp_tvalid)
      else $error("result valid right after reset");

endmodule

bind row_center_path_interval rcpi_checker u_rcpi_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);

/* tb/sv/row_interval_checker.sv */
// Checker that tracks pixel runs per row and compares each row result of the block.
`timescale 1ns / 1ps
module row_interval_checker #(
   parameter int MAX_WIDTH = 1024
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_tvalid,
   input  logic                       req_tready,
   input  logic [23:0]                req_tdata,   // red, green, blue
   input  logic                       req_tuser,   // first_of_frame
   input  logic                       req_tlast,   // last_of_row
   input  logic                       rsp_tvalid,
   input  logic                       rsp_tready,
   input  logic [23:0]                rsp_tdata,   // left_edge, right_edge, zero pad
   input  logic                       rsp_tuser,   // path_open
   input  logic                       csr_valid,
   input  logic                       csr_ready,
   input  logic [rcpi_pkg::CFG_W-1:0] csr_data,    // row_width
   output int                         outstanding,
   output int                         failures
);
   import rcpi_pkg::*;

   typedef struct packed {
      logic              open;
      logic [EDGE_W-1:0] left;
      logic [EDGE_W-1:0] right;
   } row_result_type;

   logic [CFG_W-1:0]  width_reg;
   logic [EDGE_W-1:0] column;
   logic              closed;
   logic [CFG_W-1:0]  left_mark;    // one past the last bad column left of center
   logic [CFG_W-1:0]  right_mark;   // first bad column right of center, MAX_WIDTH if none
   logic              center_good;
   row_result_type    expected_rows[$];
   int                fail_count = 0;

   function automatic logic is_bad(input logic [23:0] rgb);
      logic [COLOR_W-1:0] r, g, b;
      r = rgb[7:0];
      g = rgb[15:8];
      b = rgb[23:16];
      return (r == COLOR_FULL && g == COLOR_FULL && b == COLOR_FULL) ||
             (r == COLOR_FULL && g == COLOR_HALF && b == COLOR_NONE) ||
             (r == COLOR_NONE && g == COLOR_NONE && b == COLOR_NONE);
   endfunction

   task automatic clear_row();
      column      = '0;
      left_mark   = '0;
      right_mark  = CFG_W'(MAX_WIDTH);
      center_good = 1'b0;
   endtask

   task automatic advance_row_state(input logic [23:0] rgb, input logic first,
                                    input logic last);
      int             w, center, x, rb, right;
      logic           bad;
      row_result_type res;
      w = width_reg;
      if (w < ROW_WIDTH_MIN) w = ROW_WIDTH_MIN;
      if (w > MAX_WIDTH) w = MAX_WIDTH;
      center = w / 2;
      if (first) begin
         closed = 1'b0;
         clear_row();
      end
      x   = column;
      bad = is_bad(rgb);
      if (x == center) begin
         center_good = !bad;
      end else if (x < center) begin
         if (bad) left_mark = CFG_W'(x + 1);
      end else if (x < w - 1) begin
         if (bad && right_mark == CFG_W'(MAX_WIDTH)) right_mark = CFG_W'(x);
      end
      if (column < MAX_WIDTH - 1) column = column + 1'b1;
      if (last) begin
         if (!center_good) closed = 1'b1;
         if (closed) begin
            res = '0;
         end else begin
            rb = right_mark;
            if (rb > w - 1) rb = w - 1;
            right     = (rb > center) ? rb - 1 : center;
            res.open  = 1'b1;
            res.left  = left_mark[EDGE_W-1:0];
            res.right = EDGE_W'(right);
         end
         expected_rows.push_back(res);
         clear_row();
      end
   endtask

   task automatic compare_result();
      row_result_type    want;
      logic [EDGE_W-1:0] got_left, got_right;
      got_left  = rsp_tdata[EDGE_W-1:0];
      got_right = rsp_tdata[2*EDGE_W-1:EDGE_W];
      if (expected_rows.size() == 0) begin
         fail_count++;
         $display("%0t: row result with none pending: open %0b left %0d right %0d",
                  $time, rsp_tuser, got_left, got_right);
      end else begin
         want = expected_rows.pop_front();
         if (rsp_tuser !== want.open) begin
            fail_count++;
            $display("%0t: path_open expected %0b actual %0b", $time, want.open, rsp_tuser);
         end
         if (got_left !== want.left) begin
            fail_count++;
            $display("%0t: left_edge expected %0d actual %0d", $time, want.left, got_left);
         end
         if (got_right !== want.right) begin
            fail_count++;
            $display("%0t: right_edge expected %0d actual %0d", $time, want.right, got_right);
         end
      end
   endtask

   // Results are compared before the new pixel is tracked, so a row that ends at this
   // edge can never be matched against the result leaving at the same edge.
   always @(posedge clock) begin
      if (reset) begin
         width_reg = CFG_W'(ROW_WIDTH_RESET);
         closed    = 1'b0;
         clear_row();
         expected_rows.delete();
      end else begin
         if (csr_valid && csr_ready) width_reg = csr_data;
         if (rsp_tvalid && rsp_tready) compare_result();
         if (req_tvalid && req_tready) advance_row_state(req_tdata, req_tuser, req_tlast);
      end
      outstanding <= expected_rows.size();
      failures    <= fail_count;
   end

endmodule

/* tb/sv/row_center_path_interval_tb.sv */
// Testbench top for the row center path interval block: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps
module row_center_path_interval_tb;
   import rcpi_pkg::*;

   localparam int          MAX_WIDTH     = 1024;
   localparam int          RANDOM_PIXELS = 120;
   localparam int          PHASE_PIXELS  = 40;
   localparam int          SETTLE_CYCLES = 8;
   localparam int          LONG_HOLD     = 400;
   localparam int unsigned CYCLE_LIMIT   = 1000000;

   // Colors are packed blue, green, red from the top down, as on req_tdata.
   localparam logic [23:0] WHITE  = {COLOR_FULL, COLOR_FULL, COLOR_FULL};
   localparam logic [23:0] ORANGE = {COLOR_NONE, COLOR_HALF, COLOR_FULL};
   localparam logic [23:0] BLACK  = {COLOR_NONE, COLOR_NONE, COLOR_NONE};
   localparam logic [23:0] GREEN  = {8'd40, 8'd200, 8'd30};

   logic              clock      = 1'b0;
   logic              reset      = 1'b1;
   logic              req_tvalid = 1'b0;
   logic              req_tready;
   logic [23:0]       req_tdata  = '0;   // red, green, blue
   logic              req_tuser  = 1'b0; // first_of_frame
   logic              req_tlast  = 1'b0; // last_of_row
   logic              rsp_tvalid;
   logic              rsp_tready = 1'b0;
   logic [23:0]       rsp_tdata;         // left_edge, right_edge, zero pad
   logic              rsp_tuser;         // path_open
   logic              csr_valid  = 1'b0;
   logic              csr_ready;
   logic [CFG_W-1:0]  csr_data   = '0;   // row_width

   int                outstanding;
   int                failures;
   bit                hold_results = 1'b0;
   bit                hold_active  = 1'b0;
   bit                dense        = 1'b0;
   int unsigned       cycle_count  = 0;
   int                pixels_sent  = 0;
   int                rows_sent    = 0;
   int                settings_used = 0;
   int                row_w        = ROW_WIDTH_RESET;

   row_center_path_interval #(.MAX_WIDTH(MAX_WIDTH)) DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data)
   );

   row_interval_checker #(.MAX_WIDTH(MAX_WIDTH)) u_check (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .req_tlast   (req_tlast),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .csr_valid   (csr_valid),
      .csr_ready   (csr_ready),
      .csr_data    (csr_data),
      .outstanding (outstanding),
      .failures    (failures)
   );

   initial begin
      forever #10 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("Timed out after %0d cycles with %0d rows pending.", cycle_count, outstanding);
         $display("row_center_path_interval: mismatch");
         $finish;
      end
   end

   function automatic int idle_cycles();
      int r;
      r = $urandom_range(0, 99);
      if (r < 60) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   function automatic int clamp_width(input int v);
      if (v < ROW_WIDTH_MIN) return ROW_WIDTH_MIN;
      if (v > MAX_WIDTH) return MAX_WIDTH;
      return v;
   endfunction

   // Mostly full rows, some cut short before the end and some running past it.
   function automatic int row_length();
      int r;
      r = $urandom_range(0, 99);
      if (r < 80) return row_w;
      if (r < 90) return $urandom_range(1, row_w - 1);
      return row_w + $urandom_range(1, 3);
   endfunction

   // Near misses flip one bit of a bad color, which makes the pixel good.
   function automatic logic [23:0] pick_color(input int bad_pct);
      int          r;
      logic [23:0] base;
      r = $urandom_range(0, 99);
      case ($urandom_range(0, 2))
         0: base = WHITE;
         1: base = ORANGE;
         default: base = BLACK;
      endcase
      if (r < bad_pct) return base;
      if (r >= 85) return base ^ (24'd1 << $urandom_range(0, 23));
      return 24'($urandom);
   endfunction

   task automatic offer_pixel(input logic [23:0] rgb, input logic first, input logic last);
      bit taken;
      int gap;
      req_tvalid <= 1'b1;
      req_tdata  <= rgb;
      req_tuser  <= first;
      req_tlast  <= last;
      do begin
         @(negedge clock);
         taken = req_tready;
         @(posedge clock);
      end while (!taken);
      pixels_sent++;
      if (last) rows_sent++;
      gap = dense ? 0 : idle_cycles();
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   // The block can still hold a pixel that ends no row, so let it settle before returning.
   task automatic wait_for_results();
      bit busy;
      req_tvalid <= 1'b0;
      do begin
         @(negedge clock);
         busy = (outstanding != 0);
         @(posedge clock);
      end while (busy);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_row_width(input logic [CFG_W-1:0] value);
      bit taken;
      csr_valid <= 1'b1;
      csr_data  <= value;
      do begin
         @(negedge clock);
         taken = csr_ready;
         @(posedge clock);
      end while (!taken);
      csr_valid <= 1'b0;
      row_w = clamp_width(value);
      settings_used++;
      @(posedge clock);
   endtask

   task automatic send_row(input int length, input bit first, input int bad_pct,
                           input bit noisy);
      for (int i = 0; i < length; i++) begin
         offer_pixel(pick_color(bad_pct),
                     (i == 0 && first) || (noisy && $urandom_range(0, 99) < 3),
                     i == length - 1);
      end
   endtask

   task automatic send_frame(input int rows, input int bad_pct, input bit noisy);
      for (int i = 0; i < rows; i++) send_row(row_length(), i == 0, bad_pct, noisy);
   endtask

   // Receiver: random ready pattern, plus one long hold-off on request.
   initial begin
      int run;
      int gap;
      wait (!reset);
      @(posedge clock);
      forever begin
         if (hold_results) begin
            hold_results = 1'b0;
            hold_active  = 1'b1;
            rsp_tready <= 1'b0;
            repeat (LONG_HOLD) @(posedge clock);
            hold_active = 1'b0;
         end
         rsp_tready <= 1'b1;
         run = ($urandom_range(0, 9) == 0) ? $urandom_range(100, 300) : $urandom_range(1, 12);
         repeat (run) @(posedge clock);
         gap = idle_cycles();
         if (gap > 0) begin
            rsp_tready <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
   end

   initial begin
      int  phase_start;
      int  random_pixels;
      int  width;
      bit  started;
      random_pixels = 0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // One row at the width that reset leaves in place, ended a little past its center.
      send_row(ROW_WIDTH_RESET / 2 + 4, 1'b1, 3, 1'b0);

      // Directed rows at width four: center is column two, column three never counts.
      wait_for_results();
      write_row_width(CFG_W'(4));
      offer_pixel(WHITE, 1'b1, 1'b0);
      offer_pixel(GREEN, 1'b0, 1'b0);
      offer_pixel(GREEN, 1'b0, 1'b0);
      offer_pixel(GREEN, 1'b0, 1'b1);
      offer_pixel(GREEN, 1'b0, 1'b0);
      offer_pixel(ORANGE, 1'b0, 1'b0);
      offer_pixel(GREEN, 1'b0, 1'b0);
      offer_pixel(BLACK, 1'b0, 1'b1);
      // A bad center closes this row and the rest of the frame.
      offer_pixel(GREEN, 1'b0, 1'b0);
      offer_pixel(GREEN, 1'b0, 1'b0);
      offer_pixel(BLACK, 1'b0, 1'b0);
      offer_pixel(GREEN, 1'b0, 1'b1);
      offer_pixel(WHITE ^ 24'h010000, 1'b1, 1'b0);
      offer_pixel(ORANGE ^ 24'h000100, 1'b0, 1'b0);
      offer_pixel(BLACK ^ 24'h010000, 1'b0, 1'b0);
      offer_pixel(ORANGE ^ 24'h010000, 1'b0, 1'b1);
      // A row that ends before its center is reached.
      offer_pixel(GREEN, 1'b0, 1'b1);
      // A new frame starting in the middle of a row; the row then ends at its last column.
      offer_pixel(GREEN, 1'b0, 1'b0);
      offer_pixel(GREEN, 1'b1, 1'b0);
      offer_pixel(GREEN, 1'b0, 1'b0);
      offer_pixel(GREEN, 1'b0, 1'b0);
      offer_pixel(GREEN, 1'b0, 1'b1);

      // Two-pixel rows: the center is the last column.
      wait_for_results();
      write_row_width(CFG_W'(ROW_WIDTH_MIN));
      offer_pixel(BLACK, 1'b1, 1'b0);
      offer_pixel(GREEN, 1'b0, 1'b1);
      offer_pixel(GREEN, 1'b0, 1'b0);
      offer_pixel(WHITE, 1'b0, 1'b1);

      // Widths below the minimum.
      wait_for_results();
      write_row_width('0);
      send_frame(8, 20, 1'b0);
      wait_for_results();
      write_row_width(CFG_W'(1));
      send_frame(8, 20, 1'b1);

      // Long receiver stall under a steady pixel stream so that the block backs up.
      wait_for_results();
      write_row_width(CFG_W'(ROW_WIDTH_MIN));
      dense = 1'b1;
      hold_results = 1'b1;
      do begin
         @(negedge clock);
         started = hold_active;
         @(posedge clock);
      end while (!started);
      for (int i = 0; i < 40; i++) send_row(ROW_WIDTH_MIN, i == 0, 10, 1'b0);

      while (random_pixels < RANDOM_PIXELS) begin
         wait_for_results();
         width = ($urandom_range(0, 5) == 0) ? $urandom_range(25, 80) : $urandom_range(3, 24);
         write_row_width(CFG_W'(width));
         dense = ($urandom_range(0, 3) == 0);
         phase_start = pixels_sent;
         while (pixels_sent - phase_start < PHASE_PIXELS) begin
            send_frame($urandom_range(1, 5), $urandom_range(0, 30), $urandom_range(0, 3) == 0);
         end
         random_pixels += pixels_sent - phase_start;
      end

      wait_for_results();
      $display("Covered %0d pixels in %0d rows under %0d row width settings,",
               pixels_sent, rows_sent, settings_used);
      $display("with clamped widths, short and overlong rows, closed frames and stalls.");
      if (failures == 0 && outstanding == 0) begin
         $display("row_center_path_interval: match");
      end else begin
         $display("row_center_path_interval: mismatch");
      end
      $finish;
   end

endmodule
